/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, active through reset
`define ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/pali_pkg.sv */
// ----------------------------------------------------------------------------
// pali_pkg
// Shared constants for the polyline arc-length interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package pali_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 7;

  localparam int COORD_W    = 16;
  localparam int FRAC_W     = 17;
  localparam int POS_W      = 24;
  localparam int LEN_W      = 32;

  // square root of (dx^2 + dy^2) << 16, two radicand bits per step
  localparam int SQ_W       = 33;
  localparam int ROOT_W     = 25;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int SCNT_W     = $clog2(SQRT_STEPS);

  // offset division: 48-bit product by 32-bit segment, 24 quotient bits
  localparam int PROD_W     = 48;
  localparam int DEN_W      = 32;
  localparam int QUOT_W     = 24;
  localparam int DIV_STEPS  = QUOT_W;
  localparam int DCNT_W     = $clog2(DIV_STEPS);

  localparam logic [1:0] MODE_CLEAR    = 2'd0;
  localparam logic [1:0] MODE_APPEND   = 2'd1;
  localparam logic [1:0] MODE_QUERY    = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

endpackage

`default_nettype wire

/* sv/pali_sqrt.sv */
// ----------------------------------------------------------------------------
// pali_sqrt
// Digit-serial integer square root of radicand << 16, one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pali_sqrt (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [pali_pkg::SQ_W-1:0]    radicand_i,
  output logic                              done_o,
  output logic [pali_pkg::ROOT_W-1:0]       root_o
);

  logic [pali_pkg::RAD_W-1:0]    rad_q;
  logic [pali_pkg::SREM_W-1:0]   rem_q;
  logic [pali_pkg::ROOT_W-1:0]   root_q;
  logic [pali_pkg::SCNT_W-1:0]   cnt_q;
  logic                          busy_q, done_q;

  logic [pali_pkg::SREM_W+1:0]   rem_sh, trial, rem_sub;
  logic                          ge;

  assign rem_sh  = {rem_q, rad_q[pali_pkg::RAD_W-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == pali_pkg::SCNT_W'(pali_pkg::SQRT_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {1'b0, radicand_i, 16'b0};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[pali_pkg::RAD_W-3:0], 2'b00};
      rem_q  <= ge ? rem_sub[pali_pkg::SREM_W-1:0] : rem_sh[pali_pkg::SREM_W-1:0];
      root_q <= {root_q[pali_pkg::ROOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

/* sv/pali_div.sv */
// ----------------------------------------------------------------------------
// pali_div
// Bit-serial restoring divider for the in-segment offset, one quotient bit
// per cycle. The upper numerator half must be below the divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module pali_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [pali_pkg::PROD_W-1:0]  num_i,
  input  wire logic [pali_pkg::DEN_W-1:0]   den_i,
  output logic                              done_o,
  output logic [pali_pkg::QUOT_W-1:0]       quot_o
);

  logic [pali_pkg::DEN_W-1:0]    r_q, den_q;
  logic [pali_pkg::QUOT_W-1:0]   bits_q, quot_q;
  logic [pali_pkg::DCNT_W-1:0]   cnt_q;
  logic                          busy_q, done_q;

  logic [pali_pkg::DEN_W:0]      r_sh, r_sub;
  logic                          ge;

  assign r_sh  = {r_q, bits_q[pali_pkg::QUOT_W-1]};
  assign ge    = r_sh >= {1'b0, den_q};
  assign r_sub = r_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == pali_pkg::DCNT_W'(pali_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q    <= num_i[pali_pkg::PROD_W-1 -: pali_pkg::DEN_W];
      bits_q <= {num_i[pali_pkg::PROD_W-pali_pkg::DEN_W-1:0], 8'b0};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      r_q    <= ge ? r_sub[pali_pkg::DEN_W-1:0] : r_sh[pali_pkg::DEN_W-1:0];
      bits_q <= {bits_q[pali_pkg::QUOT_W-2:0], 1'b0};
      quot_q <= {quot_q[pali_pkg::QUOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* sv/polyline_arc_length_interpolator.sv */
// ----------------------------------------------------------------------------
// polyline_arc_length_interpolator
// Waypoint table with running arc length; clear, append, and query the point
// a fraction of the path length along it.
//
//   channel   dir  tdata                                         tuser
//   s_axis    in   point_x, point_y, position_fraction (56 b)    mode
//   m_axis    out  pos_x, pos_y, total_length, point_count,      -
//                  status (88 b)
//
// Clear, empty-path query, full-table append and first append take short
// paths. Append time is set by the 25-step serial square root. End-point
// queries skip the search; other queries are bound by the
// one-entry-a-cycle length search and the 24-step serial divider.
// Reset clears the point count; the tables need no clearing pass.
// A result waiting on m_axis holds the next item at its final step only.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_arc_length_interpolator (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [55:0]  s_axis_tdata,  // point_x, point_y, position_fraction
  input  wire logic [1:0]   s_axis_tuser,  // mode
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [87:0]       m_axis_tdata   // pos_x, pos_y, total_length,
                                           // point_count, status
);

  typedef enum logic [22:0] {
    ST_IDLE  = 23'h000001,
    ST_ARD   = 23'h000002,
    ST_AMX   = 23'h000004,
    ST_AM1   = 23'h000008,
    ST_AM2   = 23'h000010,
    ST_ASQ   = 23'h000020,
    ST_AWR   = 23'h000040,
    ST_QRDP  = 23'h000080,
    ST_QFIX  = 23'h000100,
    ST_QM0   = 23'h000200,
    ST_QM1   = 23'h000400,
    ST_QS0   = 23'h000800,
    ST_QSRCH = 23'h001000,
    ST_QPA   = 23'h002000,
    ST_QPB   = 23'h004000,
    ST_QPC   = 23'h008000,
    ST_QXL   = 23'h010000,
    ST_QXH   = 23'h020000,
    ST_QYL   = 23'h040000,
    ST_QYH   = 23'h080000,
    ST_QDS   = 23'h100000,
    ST_QDW   = 23'h200000,
    ST_OUT   = 23'h400000
  } state_e;

  state_e state_q;

  logic [pali_pkg::CNT_W-1:0]   cnt_q;
  logic [pali_pkg::LEN_W-1:0]   total_q;
  logic [pali_pkg::COORD_W-1:0] x_in_q, y_in_q, x0_q, y0_q;
  logic [15:0]                  t_q;
  logic [pali_pkg::IDX_W-1:0]   idx_q;
  logic [pali_pkg::LEN_W-1:0]   target_q, c0_q, c1_q, rem_q, seg_q;
  logic signed [16:0]           dx_q, dy_q;
  logic [15:0]                  mag_x_q, mag_y_q;
  logic                         neg_x_q, neg_y_q;
  logic [31:0]                  prod_q;
  logic [pali_pkg::PROD_W-1:0]  px_q, py_q;
  logic [pali_pkg::POS_W-1:0]   pos_x_q, pos_y_q;
  logic                         status_q;
  logic                         m_valid_q;
  logic [87:0]                  m_data_q;

  logic [31:0] wp_mem  [pali_pkg::MAX_POINTS];
  logic [31:0] cum_mem [pali_pkg::MAX_POINTS];
  logic [31:0] wp_rd_q, cum_rd_q;
  logic [pali_pkg::IDX_W-1:0] rd_addr;
  logic wr_en;

  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;

  logic [1:0]                 in_mode;
  logic [15:0]                in_x, in_y;
  logic [pali_pkg::FRAC_W-1:0] in_t;
  logic                       in_acc, out_load;

  logic                         sqrt_done, div_x_done, div_y_done;
  logic [pali_pkg::ROOT_W-1:0]  root;
  logic [pali_pkg::QUOT_W-1:0]  quot_x, quot_y;
  logic [pali_pkg::SQ_W-1:0]    sq_sum;
  logic [pali_pkg::LEN_W:0]     cum_sum;
  logic [pali_pkg::LEN_W-1:0]   cum_new, seg_w;
  logic [16:0]                  qdx, qdy, qdx_abs, qdy_abs;
  logic [pali_pkg::POS_W-1:0]   base_x, base_y;

  assign in_mode = s_axis_tuser;
  assign in_x    = s_axis_tdata[15:0];
  assign in_y    = s_axis_tdata[31:16];
  assign in_t    = s_axis_tdata[48:32];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    case (state_q)
      ST_ARD:   rd_addr = pali_pkg::IDX_W'(cnt_q - 1'b1);
      ST_QS0:   rd_addr = idx_q + 1'b1;
      ST_QSRCH: rd_addr = idx_q + 2'd2;
      ST_QPB:   rd_addr = idx_q + 1'b1;
      default:  rd_addr = idx_q;
    endcase
  end

  assign wr_en = (state_q == ST_AWR);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wp_mem[cnt_q[pali_pkg::IDX_W-1:0]]  <= {y_in_q, x_in_q};
      cum_mem[cnt_q[pali_pkg::IDX_W-1:0]] <= cum_new;
    end
    wp_rd_q  <= wp_mem[rd_addr];
    cum_rd_q <= cum_mem[rd_addr];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_AM1: begin mul_a = dx_q; mul_b = dx_q; end
      ST_AM2: begin mul_a = dy_q; mul_b = dy_q; end
      ST_QM0: begin mul_a = {1'b0, t_q}; mul_b = {1'b0, total_q[15:0]}; end
      ST_QM1: begin mul_a = {1'b0, t_q}; mul_b = {1'b0, total_q[31:16]}; end
      ST_QXL: begin mul_a = {1'b0, mag_x_q}; mul_b = {1'b0, rem_q[15:0]}; end
      ST_QXH: begin mul_a = {1'b0, mag_x_q}; mul_b = {1'b0, rem_q[31:16]}; end
      ST_QYL: begin mul_a = {1'b0, mag_y_q}; mul_b = {1'b0, rem_q[15:0]}; end
      ST_QYH: begin mul_a = {1'b0, mag_y_q}; mul_b = {1'b0, rem_q[31:16]}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign sq_sum  = {1'b0, prod_q} + mul_p[pali_pkg::SQ_W-1:0];
  assign cum_sum = {1'b0, total_q} + (pali_pkg::LEN_W+1)'(root);
  assign cum_new = (cnt_q == '0) ? '0 :
                   (cum_sum[pali_pkg::LEN_W] ? '1 : cum_sum[pali_pkg::LEN_W-1:0]);

  assign qdx     = {wp_rd_q[15], wp_rd_q[15:0]} - {x0_q[15], x0_q};
  assign qdy     = {wp_rd_q[31], wp_rd_q[31:16]} - {y0_q[15], y0_q};
  assign qdx_abs = qdx[16] ? (17'd0 - qdx) : qdx;
  assign qdy_abs = qdy[16] ? (17'd0 - qdy) : qdy;
  assign seg_w   = c1_q - c0_q;
  assign base_x  = {x0_q, 8'b0};
  assign base_y  = {y0_q, 8'b0};

  pali_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_AM2),
    .radicand_i (sq_sum),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  pali_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_QDS),
    .num_i   (px_q),
    .den_i   (seg_q),
    .done_o  (div_x_done),
    .quot_o  (quot_x)
  );

  pali_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_QDS),
    .num_i   (py_q),
    .den_i   (seg_q),
    .done_o  (div_y_done),
    .quot_o  (quot_y)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      total_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_mode)
              pali_pkg::MODE_CLEAR: begin
                cnt_q   <= '0;
                total_q <= '0;
                state_q <= ST_OUT;
              end
              pali_pkg::MODE_APPEND: begin
                if (cnt_q >= pali_pkg::CNT_W'(pali_pkg::MAX_POINTS)) begin
                  state_q <= ST_OUT;
                end else if (cnt_q == '0) begin
                  state_q <= ST_AWR;
                end else begin
                  state_q <= ST_ARD;
                end
              end
              pali_pkg::MODE_QUERY: begin
                if (cnt_q == '0) begin
                  state_q <= ST_OUT;
                end else if (cnt_q == pali_pkg::CNT_W'(1) || in_t == '0 || in_t[16]) begin
                  state_q <= ST_QRDP;
                end else begin
                  state_q <= ST_QM0;
                end
              end
              default: state_q <= ST_OUT;
            endcase
          end
        end
        ST_ARD:  state_q <= ST_AMX;
        ST_AMX:  state_q <= ST_AM1;
        ST_AM1:  state_q <= ST_AM2;
        ST_AM2:  state_q <= ST_ASQ;
        ST_ASQ:  if (sqrt_done) state_q <= ST_AWR;
        ST_AWR: begin
          cnt_q   <= cnt_q + 1'b1;
          total_q <= cum_new;
          state_q <= ST_OUT;
        end
        ST_QRDP: state_q <= ST_QFIX;
        ST_QFIX: state_q <= ST_OUT;
        ST_QM0:  state_q <= ST_QM1;
        ST_QM1:  state_q <= ST_QS0;
        ST_QS0:  state_q <= ST_QSRCH;
        ST_QSRCH: if (cum_rd_q >= target_q) state_q <= ST_QPA;
        ST_QPA:  state_q <= ST_QPB;
        ST_QPB:  state_q <= ST_QPC;
        ST_QPC: begin
          if (seg_w == '0 || target_q < c0_q) begin
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_QXL;
          end
        end
        ST_QXL:  state_q <= ST_QXH;
        ST_QXH:  state_q <= ST_QYL;
        ST_QYL:  state_q <= ST_QYH;
        ST_QYH:  state_q <= ST_QDS;
        ST_QDS:  state_q <= ST_QDW;
        ST_QDW:  if (div_x_done && div_y_done) state_q <= ST_OUT;
        ST_OUT:  if (out_load) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          x_in_q   <= in_x;
          y_in_q   <= in_y;
          t_q      <= in_t[15:0];
          pos_x_q  <= '0;
          pos_y_q  <= '0;
          status_q <= (in_mode == pali_pkg::MODE_APPEND) &&
                      (cnt_q >= pali_pkg::CNT_W'(pali_pkg::MAX_POINTS));
          idx_q    <= in_t[16] ? pali_pkg::IDX_W'(cnt_q - 1'b1) : '0;
        end
      end
      ST_AMX: begin
        dx_q <= $signed({x_in_q[15], x_in_q} - {wp_rd_q[15], wp_rd_q[15:0]});
        dy_q <= $signed({y_in_q[15], y_in_q} - {wp_rd_q[31], wp_rd_q[31:16]});
      end
      ST_AM1: prod_q <= mul_p[31:0];
      ST_QFIX: begin
        pos_x_q <= {wp_rd_q[15:0], 8'b0};
        pos_y_q <= {wp_rd_q[31:16], 8'b0};
      end
      ST_QM0: prod_q <= mul_p[31:0];
      ST_QM1: begin
        target_q <= mul_p[31:0] + {16'b0, prod_q[31:16]};
        idx_q    <= '0;
      end
      ST_QSRCH: begin
        if (cum_rd_q >= target_q) begin
          c1_q <= cum_rd_q;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      ST_QPB: begin
        x0_q <= wp_rd_q[15:0];
        y0_q <= wp_rd_q[31:16];
        c0_q <= cum_rd_q;
      end
      ST_QPC: begin
        pos_x_q <= base_x;
        pos_y_q <= base_y;
        mag_x_q <= qdx_abs[15:0];
        mag_y_q <= qdy_abs[15:0];
        neg_x_q <= qdx[16];
        neg_y_q <= qdy[16];
        rem_q   <= target_q - c0_q;
        seg_q   <= seg_w;
      end
      ST_QXL: prod_q <= mul_p[31:0];
      ST_QXH: px_q <= {mul_p[31:0], 16'b0} + {16'b0, prod_q};
      ST_QYL: prod_q <= mul_p[31:0];
      ST_QYH: py_q <= {mul_p[31:0], 16'b0} + {16'b0, prod_q};
      ST_QDW: begin
        if (div_x_done) begin
          pos_x_q <= neg_x_q ? base_x - quot_x : base_x + quot_x;
          pos_y_q <= neg_y_q ? base_y - quot_y : base_y + quot_y;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      m_data_q <= {status_q, cnt_q, total_q, pos_y_q, pos_x_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

/* sv/pali_chk.sv */
// ----------------------------------------------------------------------------
// pali_chk
// Port-level checks on the interpolator result stream.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pali_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [87:0] m_axis_tdata
);

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
  `ASSERT_CLK(a_cnt_max, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[86:80] <= 7'(pali_pkg::MAX_POINTS), "point count above table size")
  `ASSERT_CLK(a_full_flag, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[87] |-> m_axis_tdata[86:80] == 7'(pali_pkg::MAX_POINTS), "drop flag without full table")
  `ASSERT_CLK(a_short_len, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[86:80] < 7'd2 |-> m_axis_tdata[79:48] == 32'd0, "length nonzero on short path")
  `ASSERT_ANY(a_rst_quiet, clk_i, !rst_ni |=> !m_axis_tvalid, "result valid out of reset")

endmodule

bind polyline_arc_length_interpolator pali_chk u_pali_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* bench/tb_polyline_arc_length_interpolator.sv */
// ----------------------------------------------------------------------------
// tb_polyline_arc_length_interpolator
// Streams clear, append and query items into the interpolator, predicts each
// result from a behavioral copy of the waypoint and arc-length tables, and
// compares every output transfer field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_polyline_arc_length_interpolator;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] px;
    logic [15:0] py;
    logic [16:0] frac;
  } path_cmd_t;

  typedef struct packed {
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic [31:0] total;
    logic [6:0]  count;
    logic        status;
  } path_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;

  polyline_arc_length_interpolator u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  path_cmd_t cmd_q[$];
  path_res_t expected_q[$];
  int        n_fail = 0;
  bit        hold_long = 1'b0;
  int        n_out = 0;

  // behavioral path state
  logic signed [15:0] wp_x[pali_pkg::MAX_POINTS];
  logic signed [15:0] wp_y[pali_pkg::MAX_POINTS];
  logic [31:0]        cum_len[pali_pkg::MAX_POINTS];
  int                 wp_count = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic path_res_t apply_path_cmd(path_cmd_t c);
    path_res_t r;
    longint sx, sy, dx, dy, rem;
    longint unsigned sq, seg, sum, target;
    int n;
    bit hit;
    r = '0;
    sx = 0;
    sy = 0;
    n = wp_count;
    if (c.mode == pali_pkg::MODE_CLEAR) begin
      wp_count = 0;
    end else if (c.mode == pali_pkg::MODE_APPEND) begin
      if (n >= pali_pkg::MAX_POINTS) begin
        r.status = 1'b1;
      end else begin
        sum = 0;
        if (n > 0) begin
          dx = longint'($signed(c.px)) - wp_x[n-1];
          dy = longint'($signed(c.py)) - wp_y[n-1];
          sq = dx * dx + dy * dy;
          seg = int_sqrt(sq << 16);
          sum = cum_len[n-1] + seg;
          if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
        end
        wp_x[n] = c.px;
        wp_y[n] = c.py;
        cum_len[n] = sum[31:0];
        wp_count = n + 1;
      end
    end else if (c.mode == pali_pkg::MODE_QUERY && n > 0) begin
      if (n == 1 || c.frac == 0) begin
        sx = wp_x[0] * 256;
        sy = wp_y[0] * 256;
      end else if (c.frac >= 17'd65536) begin
        sx = wp_x[n-1] * 256;
        sy = wp_y[n-1] * 256;
      end else begin
        target = (longint'(c.frac) * cum_len[n-1]) >> 16;
        sx = wp_x[n-1] * 256;
        sy = wp_y[n-1] * 256;
        hit = 1'b0;
        for (int i = 0; i + 1 < n && !hit; i++) begin
          if (cum_len[i+1] >= target) begin
            hit = 1'b1;
            seg = cum_len[i+1] - cum_len[i];
            sx = wp_x[i] * 256;
            sy = wp_y[i] * 256;
            if (seg != 0 && target >= cum_len[i]) begin
              rem = target - cum_len[i];
              dx = longint'(wp_x[i+1]) - wp_x[i];
              dy = longint'(wp_y[i+1]) - wp_y[i];
              sx += (dx * rem * 256) / longint'(seg);
              sy += (dy * rem * 256) / longint'(seg);
            end
          end
        end
      end
    end
    r.pos_x = sx[23:0];
    r.pos_y = sy[23:0];
    r.total = (wp_count < 2) ? 32'd0 : cum_len[wp_count-1];
    r.count = wp_count[6:0];
    return r;
  endfunction

  function automatic int gap_len();
    int k = $urandom_range(0, 19);
    if (k < 10) return 0;
    if (k < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  int        tx_gap = 0;
  path_cmd_t tx_cmd;
  path_res_t tx_res;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        tx_res = apply_path_cmd(tx_cmd);
        expected_q = {expected_q, tx_res};
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          tx_cmd = cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= tx_cmd.mode;
          s_axis_tdata <= {7'd0, tx_cmd.frac, tx_cmd.py, tx_cmd.px};
          tx_gap <= gap_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int rx_gap = 0;
  always @(posedge clk_i) begin
    path_res_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_out <= n_out + 1;
        got.pos_x  = m_axis_tdata[23:0];
        got.pos_y  = m_axis_tdata[47:24];
        got.total  = m_axis_tdata[79:48];
        got.count  = m_axis_tdata[86:80];
        got.status = m_axis_tdata[87];
        if (expected_q.size() == 0) begin
          $error("unexpected output transfer %h", m_axis_tdata);
          n_fail++;
        end else begin
          want = expected_q.pop_front();
          if (got.pos_x !== want.pos_x) begin
            $error("pos_x expected %h actual %h", want.pos_x, got.pos_x);
            n_fail++;
          end
          if (got.pos_y !== want.pos_y) begin
            $error("pos_y expected %h actual %h", want.pos_y, got.pos_y);
            n_fail++;
          end
          if (got.total !== want.total) begin
            $error("total_length expected %h actual %h", want.total, got.total);
            n_fail++;
          end
          if (got.count !== want.count) begin
            $error("point_count expected %0d actual %0d", want.count, got.count);
            n_fail++;
          end
          if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            n_fail++;
          end
        end
      end
      if (hold_long) begin
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_gap <= gap_len();
      end
    end
  end

  // long receiver stall
  initial begin
    wait (rst_ni);
    wait (n_out >= 300);
    @(posedge clk_i);
    hold_long <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_long <= 1'b0;
  end

  function automatic path_cmd_t mk(logic [1:0] m, int x, int y, int f);
    path_cmd_t c;
    c.mode = m;
    c.px = x[15:0];
    c.py = y[15:0];
    c.frac = f[16:0];
    return c;
  endfunction

  function automatic void add_cmd(path_cmd_t c);
    cmd_q = {cmd_q, c};
  endfunction

  function automatic int rnd_coord(bit near);
    if (near) return $urandom_range(0, 400) - 200;
    return $urandom_range(0, 65535) - 32768;
  endfunction

  initial begin
    int items, pts;
    bit near;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed
    add_cmd(mk(pali_pkg::MODE_QUERY, 0, 0, 30000));
    add_cmd(mk(pali_pkg::MODE_APPEND, -32768, 32767, 0));
    add_cmd(mk(pali_pkg::MODE_QUERY, 0, 0, 40000));
    add_cmd(mk(pali_pkg::MODE_APPEND, 32767, -32768, 0));
    add_cmd(mk(pali_pkg::MODE_APPEND, 32767, -32768, 0));
    add_cmd(mk(pali_pkg::MODE_APPEND, 100, 100, 0));
    add_cmd(mk(pali_pkg::MODE_QUERY, 0, 0, 0));
    add_cmd(mk(pali_pkg::MODE_QUERY, 0, 0, 65536));
    add_cmd(mk(pali_pkg::MODE_QUERY, 0, 0, 131071));
    add_cmd(mk(pali_pkg::MODE_QUERY, 0, 0, 32768));
    add_cmd(mk(pali_pkg::MODE_QUERY, 0, 0, 65535));
    add_cmd(mk(pali_pkg::MODE_QUERY, 0, 0, 1));
    add_cmd(mk(pali_pkg::MODE_RESERVED, 5, 5, 5));
    add_cmd(mk(pali_pkg::MODE_CLEAR, -1, -1, 131071));
    add_cmd(mk(pali_pkg::MODE_APPEND, 7, 7, 0));
    add_cmd(mk(pali_pkg::MODE_APPEND, 7, 7, 0));
    add_cmd(mk(pali_pkg::MODE_QUERY, 0, 0, 20000));
    // fill the table past its end with the longest segments
    add_cmd(mk(pali_pkg::MODE_CLEAR, 0, 0, 0));
    for (int i = 0; i < pali_pkg::MAX_POINTS + 2; i++)
      add_cmd(mk(pali_pkg::MODE_APPEND, (i % 2) ? 32767 : -32768,
                 (i % 2) ? -32768 : 32767, 0));
    for (int i = 0; i < 6; i++)
      add_cmd(mk(pali_pkg::MODE_QUERY, 0, 0, $urandom_range(0, 65536)));
    // random paths
    items = 0;
    while (items < 2000) begin
      near = $urandom_range(0, 1);
      if ($urandom_range(0, 9) != 0) add_cmd(mk(pali_pkg::MODE_CLEAR, 0, 0, 0));
      pts = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 8);
      for (int i = 0; i < pts; i++)
        add_cmd(mk(pali_pkg::MODE_APPEND, rnd_coord(near), rnd_coord(near),
                   $urandom_range(0, 131071)));
      for (int i = $urandom_range(1, 8); i > 0; i--)
        add_cmd(mk(($urandom_range(0, 19) == 0) ? pali_pkg::MODE_RESERVED
                                                : pali_pkg::MODE_QUERY,
                   rnd_coord(0), rnd_coord(0),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(65536, 131071)
                                               : $urandom_range(0, 65535)));
      items += pts + 5;
    end
    wait (cmd_q.size() == 0 && !s_axis_tvalid);
    wait (expected_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (n_fail == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire
